// ===== hw/rtl/isf_pkg.sv =====
// Shared constants, types and fixed-point coefficients for the ionospheric
// slant mapping factor pipeline. No dependencies.
`default_nettype none

package isf_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int ELEV_W          = 23;
  localparam int FACTOR_W        = 32;
  localparam int MODEL_W         = 2;
  localparam int Z_W             = 31;  // degrees, 24 fraction bits
  localparam int Z_SHIFT         = 24 - ANGLE_FRAC_BITS;
  localparam int X_W             = 31;  // radians, 30 fraction bits
  localparam int SIN_W           = 31;
  localparam int U_W             = 31;
  localparam int QUOT_W          = 36;  // 2^62 / u, u above 2^26
  localparam int ROOT_W          = 32;

  localparam logic [MODEL_W-1:0] MODEL_NONE = 2'd0;
  localparam logic [MODEL_W-1:0] MODEL_SLM  = 2'd1;
  localparam logic [MODEL_W-1:0] MODEL_MSLM = 2'd2;
  localparam logic [MODEL_W-1:0] MODEL_ESM  = 2'd3;

  localparam logic [ELEV_W-1:0] ELEV_90 = ELEV_W'(64'd90 << ANGLE_FRAC_BITS);
  localparam logic [ELEV_W-1:0] ELEV_80 = ELEV_W'(64'd80 << ANGLE_FRAC_BITS);

  localparam logic [FACTOR_W-1:0] ONE_Q30  = FACTOR_W'(64'd1 << 30);
  localparam logic [31:0]         PI_Q30   = 32'd3373259426;
  localparam logic [29:0] ALPHA_Q30 = 30'(((64'd9782 << 30) + 64'd5000) / 64'd10000);
  localparam logic [29:0] K_SLM_Q30 = 30'(((64'd6371 << 30) + 64'd3410) / 64'd6821);
  localparam logic [29:0] K_MSLM_Q30 =
    30'(((64'd63710 << 30) + 64'd34388) / 64'd68777);
  localparam logic [Z_W-1:0] DEG90_Q24 = Z_W'(64'd90 << 24);

  // floor(n/d) = (n * ceil(2^32/d)) >> 32, exact for n below 2^24
  localparam logic [5:0]  XDIV       = 6'd45;
  localparam logic [26:0] XDIV_RECIP = 27'(((64'd1 << 32) + 64'd44) / 64'd45);

  localparam int HORNER_STEPS = 7;
  localparam logic [7:0] HORNER_DIV [HORNER_STEPS] =
    '{8'd210, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [29:0] HORNER_RECIP [HORNER_STEPS] = '{
    30'(((64'd1 << 32) + 64'd209) / 64'd210),
    30'(((64'd1 << 32) + 64'd155) / 64'd156),
    30'(((64'd1 << 32) + 64'd109) / 64'd110),
    30'(((64'd1 << 32) + 64'd71) / 64'd72),
    30'(((64'd1 << 32) + 64'd41) / 64'd42),
    30'(((64'd1 << 32) + 64'd19) / 64'd20),
    30'(((64'd1 << 32) + 64'd5) / 64'd6)
  };

  typedef struct packed {
    logic valid;
    logic bypass;
    logic mslm;
  } isf_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/isf_sine.sv =====
// Pipelined Q30 sine: square, seven Horner steps of four stages each, final
// product. Depends on isf_pkg.
`default_nettype none

module isf_sine (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  isf_pkg::isf_ctl_t           in_ctl,
  input  logic [isf_pkg::X_W-1:0]     x,
  output isf_pkg::isf_ctl_t           out_ctl,
  output logic [isf_pkg::SIN_W-1:0]   sin_val
);

  isf_pkg::isf_ctl_t           st_ctl [isf_pkg::HORNER_STEPS+1];
  logic [isf_pkg::X_W-1:0]     st_x   [isf_pkg::HORNER_STEPS+1];
  logic [31:0]                 st_x2  [isf_pkg::HORNER_STEPS+1];
  logic [30:0]                 st_t   [isf_pkg::HORNER_STEPS+1];

  isf_pkg::isf_ctl_t       sq_ctl;
  logic [isf_pkg::X_W-1:0] sq_x;
  logic [31:0]             sq_x2;
  logic [61:0]             sq_prod;
  logic [61:0]             fin_prod;

  assign sq_prod = 62'(x) * 62'(x);

  always_ff @(posedge clk) begin
    if (rst) sq_ctl <= '0;
    else if (en) sq_ctl <= in_ctl;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x  <= x;
      sq_x2 <= sq_prod[61:30];
    end
  end

  assign st_ctl[0] = sq_ctl;
  assign st_x[0]   = sq_x;
  assign st_x2[0]  = sq_x2;
  assign st_t[0]   = 31'(isf_pkg::ONE_Q30);

  for (genvar g = 0; g < isf_pkg::HORNER_STEPS; g++) begin : g_step
    isf_pkg::isf_ctl_t       a_ctl, b_ctl, c_ctl, d_ctl;
    logic [isf_pkg::X_W-1:0] a_x, b_x, c_x, d_x;
    logic [31:0]             a_x2, b_x2, c_x2, d_x2;
    logic [31:0]             a_n;
    logic [15:0]             b_qh, b_nh, b_nl;
    logic [15:0]             c_qh;
    logic [23:0]             c_n2;
    logic [30:0]             d_t;
    logic [62:0]             mul_p;
    logic [47:0]             qh_prod;
    logic [23:0]             rem_full;
    logic [55:0]             ql_prod;
    logic [31:0]             quot;

    assign mul_p    = 63'(st_x2[g]) * 63'(st_t[g]);
    assign qh_prod  = 48'(a_n[31:16]) * 48'(isf_pkg::HORNER_RECIP[g]);
    assign rem_full = 24'(b_nh) - 24'(b_qh) * 24'(isf_pkg::HORNER_DIV[g]);
    assign ql_prod  = 56'(c_n2) * 56'(isf_pkg::HORNER_RECIP[g]);
    assign quot     = {c_qh, 16'd0} + 32'(ql_prod[48:32]);

    always_ff @(posedge clk) begin
      if (rst) begin
        a_ctl <= '0;
        b_ctl <= '0;
        c_ctl <= '0;
        d_ctl <= '0;
      end else if (en) begin
        a_ctl <= st_ctl[g];
        b_ctl <= a_ctl;
        c_ctl <= b_ctl;
        d_ctl <= c_ctl;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_x  <= st_x[g];
        a_x2 <= st_x2[g];
        a_n  <= 32'(mul_p >> 30);
        b_x  <= a_x;
        b_x2 <= a_x2;
        b_qh <= qh_prod[47:32];
        b_nh <= a_n[31:16];
        b_nl <= a_n[15:0];
        c_x  <= b_x;
        c_x2 <= b_x2;
        c_qh <= b_qh;
        c_n2 <= {rem_full[7:0], b_nl};
        d_x  <= c_x;
        d_x2 <= c_x2;
        d_t  <= 31'(32'(isf_pkg::ONE_Q30) - quot);
      end
    end

    assign st_ctl[g+1] = d_ctl;
    assign st_x[g+1]   = d_x;
    assign st_x2[g+1]  = d_x2;
    assign st_t[g+1]   = d_t;
  end

  assign fin_prod = 62'(st_x[isf_pkg::HORNER_STEPS]) * 62'(st_t[isf_pkg::HORNER_STEPS]);

  always_ff @(posedge clk) begin
    if (rst) out_ctl <= '0;
    else if (en) out_ctl <= st_ctl[isf_pkg::HORNER_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) sin_val <= fin_prod[60:30];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/isf_rsqrt.sv =====
// Pipelined 1/sqrt(u) in Q30: restoring divide of 2^62 by u, one quotient
// bit a stage, then digit-by-digit square root, one root bit a stage.
// Depends on isf_pkg.
`default_nettype none

module isf_rsqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  isf_pkg::isf_ctl_t            in_ctl,
  input  logic [isf_pkg::U_W-1:0]      u,
  output isf_pkg::isf_ctl_t            out_ctl,
  output logic [isf_pkg::ROOT_W-1:0]   root
);

  isf_pkg::isf_ctl_t            dv_ctl [isf_pkg::QUOT_W+1];
  logic [isf_pkg::U_W-1:0]      dv_u   [isf_pkg::QUOT_W+1];
  logic [isf_pkg::U_W-1:0]      dv_rem [isf_pkg::QUOT_W+1];
  logic [isf_pkg::QUOT_W-1:0]   dv_q   [isf_pkg::QUOT_W+1];

  isf_pkg::isf_ctl_t            sq_ctl  [isf_pkg::ROOT_W+1];
  logic [isf_pkg::QUOT_W-1:0]   sq_w    [isf_pkg::ROOT_W+1];
  logic [33:0]                  sq_rem  [isf_pkg::ROOT_W+1];
  logic [isf_pkg::ROOT_W-1:0]   sq_root [isf_pkg::ROOT_W+1];

  // 2^62 shifted down to the top quotient bit
  assign dv_ctl[0] = in_ctl;
  assign dv_u[0]   = u;
  assign dv_rem[0] = isf_pkg::U_W'(64'd1 << (62 - isf_pkg::QUOT_W));
  assign dv_q[0]   = '0;

  for (genvar i = 0; i < isf_pkg::QUOT_W; i++) begin : g_div
    logic [isf_pkg::U_W:0] sh;
    logic                  ge;

    assign sh = {dv_rem[i], 1'b0};
    assign ge = sh >= {1'b0, dv_u[i]};

    always_ff @(posedge clk) begin
      if (rst) dv_ctl[i+1] <= '0;
      else if (en) dv_ctl[i+1] <= dv_ctl[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_u[i+1]   <= dv_u[i];
        dv_rem[i+1] <= ge ? isf_pkg::U_W'(sh - {1'b0, dv_u[i]}) : isf_pkg::U_W'(sh);
        dv_q[i+1]   <= {dv_q[i][isf_pkg::QUOT_W-2:0], ge};
      end
    end
  end

  assign sq_ctl[0]  = dv_ctl[isf_pkg::QUOT_W];
  assign sq_w[0]    = dv_q[isf_pkg::QUOT_W];
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar j = 0; j < isf_pkg::ROOT_W; j++) begin : g_sqrt
    logic [63:0] v;
    logic [35:0] cur;
    logic [35:0] trial;
    logic        ge;

    assign v     = {sq_w[j], 28'd0};
    assign cur   = {sq_rem[j], v[63-2*j -: 2]};
    assign trial = 36'({sq_root[j], 2'b01});
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) sq_ctl[j+1] <= '0;
      else if (en) sq_ctl[j+1] <= sq_ctl[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_w[j+1]    <= sq_w[j];
        sq_rem[j+1]  <= ge ? 34'(cur - trial) : 34'(cur);
        sq_root[j+1] <= {sq_root[j][isf_pkg::ROOT_W-2:0], ge};
      end
    end
  end

  assign out_ctl = sq_ctl[isf_pkg::ROOT_W];
  assign root    = sq_root[isf_pkg::ROOT_W];

endmodule

`default_nettype wire

// ===== hw/rtl/iono_slant_mapping_factor.sv =====
// Ionospheric single-layer slant mapping factor, fully pipelined.
// Depends on isf_pkg, isf_sine, isf_rsqrt.
//
//   channel   dir   handshake                 payload
//   config    in    cfg_wr_en                 cfg_wr_data (map_model)
//   input     in    in_valid / in_ready       elevation_deg
//   output    out   out_valid / out_ready     map_factor
//
// One elevation per cycle while in_ready is high.
// The pipe holds the bit-per-stage divider (36) and square root (32)
// plus the seven four-stage Horner steps of the sine.
// Synchronous reset clears valid bits and sets map_model to MSLM.
// A two-entry output buffer holds results; the whole pipe stalls only when
// both entries are full.
`default_nettype none

module iono_slant_mapping_factor (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [isf_pkg::MODEL_W-1:0]     cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [isf_pkg::ELEV_W-1:0]      elevation_deg,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [isf_pkg::FACTOR_W-1:0]    map_factor
);

  logic [isf_pkg::MODEL_W-1:0] map_model;
  logic                        en;

  logic [isf_pkg::ELEV_W-1:0]  e_sat;
  logic [isf_pkg::ELEV_W-1:0]  z;
  isf_pkg::isf_ctl_t           ctl_in;

  isf_pkg::isf_ctl_t           s1_ctl, s2_ctl, s3_ctl, s4_ctl, s5_ctl, s6_ctl;
  logic [isf_pkg::Z_W-1:0]     s1_z24, s2_za;
  logic [36:0]                 s3_q;
  logic [13:0]                 s4_h, s5_h;
  logic [18:0]                 s4_qh;
  logic [17:0]                 s4_ql;
  logic [23:0]                 s5_n2;
  logic [isf_pkg::X_W-1:0]     s6_x;

  logic [60:0]                 alpha_prod;
  logic [60:0]                 alpha_rnd;
  logic [62:0]                 pi_prod;
  logic [47:0]                 h_prod;
  logic [18:0]                 xrem;
  logic [55:0]                 l_prod;

  isf_pkg::isf_ctl_t           sin_ctl, sk_ctl, su_ctl, rs_ctl;
  logic [isf_pkg::SIN_W-1:0]   sin_val;
  logic [29:0]                 k_sel;
  logic [60:0]                 k_prod;
  logic [isf_pkg::SIN_W-1:0]   sk_s;
  logic [61:0]                 s_sq;
  logic [isf_pkg::U_W-1:0]     su_u;
  logic [isf_pkg::ROOT_W-1:0]  root;

  logic                        push;
  logic [isf_pkg::FACTOR_W-1:0] push_data;
  logic                        skid_valid;
  logic [isf_pkg::FACTOR_W-1:0] skid_data;

  always_ff @(posedge clk) begin
    if (rst) map_model <= isf_pkg::MODEL_MSLM;
    else if (cfg_wr_en) map_model <= cfg_wr_data;
  end

  assign en       = !skid_valid;
  assign in_ready = en;

  // front end: saturate, zenith angle, mode flags
  assign e_sat = (elevation_deg > isf_pkg::ELEV_90) ? isf_pkg::ELEV_90 : elevation_deg;
  assign z     = isf_pkg::ELEV_90 - e_sat;

  always_comb begin
    ctl_in.valid  = in_valid;
    ctl_in.mslm   = map_model == isf_pkg::MODEL_MSLM;
    ctl_in.bypass = !((map_model == isf_pkg::MODEL_SLM) ||
                      ((map_model == isf_pkg::MODEL_MSLM) && (z <= isf_pkg::ELEV_80)));
  end

  assign alpha_prod = 61'(s1_z24) * 61'(isf_pkg::ALPHA_Q30);
  assign alpha_rnd  = alpha_prod + (61'd1 << 29);
  assign pi_prod    = 63'(s2_za) * 63'(isf_pkg::PI_Q30) + 63'(isf_pkg::DEG90_Q24);
  assign h_prod     = 48'(s3_q[36:18]) * 48'(isf_pkg::XDIV_RECIP);
  assign xrem       = s4_qh - 19'(s4_h) * 19'(isf_pkg::XDIV);
  assign l_prod     = 56'(s5_n2) * 56'(isf_pkg::XDIV_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
      s2_ctl <= '0;
      s3_ctl <= '0;
      s4_ctl <= '0;
      s5_ctl <= '0;
      s6_ctl <= '0;
    end else if (en) begin
      s1_ctl <= ctl_in;
      s2_ctl <= s1_ctl;
      s3_ctl <= s2_ctl;
      s4_ctl <= s3_ctl;
      s5_ctl <= s4_ctl;
      s6_ctl <= s5_ctl;
    end
  end

  // MSLM alpha scaling, then degrees to radians: floor(q / 45) split into two narrow divides
  always_ff @(posedge clk) begin
    if (en) begin
      s1_z24 <= isf_pkg::Z_W'(z) << isf_pkg::Z_SHIFT;
      s2_za  <= s1_ctl.mslm ? isf_pkg::Z_W'(alpha_rnd >> 30) : s1_z24;
      s3_q   <= 37'(pi_prod >> 26);
      s4_h   <= h_prod[45:32];
      s4_qh  <= s3_q[36:18];
      s4_ql  <= s3_q[17:0];
      s5_h   <= s4_h;
      s5_n2  <= {xrem[5:0], s4_ql};
      s6_x   <= isf_pkg::X_W'({s5_h, 18'd0} + 32'(l_prod[49:32]));
    end
  end

  isf_sine u_sine (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_ctl  (s6_ctl),
    .x       (s6_x),
    .out_ctl (sin_ctl),
    .sin_val (sin_val)
  );

  assign k_sel  = sin_ctl.mslm ? isf_pkg::K_MSLM_Q30 : isf_pkg::K_SLM_Q30;
  assign k_prod = 61'(k_sel) * 61'(sin_val);
  assign s_sq   = 62'(sk_s) * 62'(sk_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      sk_ctl <= '0;
      su_ctl <= '0;
    end else if (en) begin
      sk_ctl <= sin_ctl;
      su_ctl <= sk_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sk_s <= isf_pkg::SIN_W'(k_prod >> 30);
      su_u <= isf_pkg::U_W'(32'(isf_pkg::ONE_Q30) - 32'(s_sq >> 30));
    end
  end

  isf_rsqrt u_rsqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_ctl  (su_ctl),
    .u       (su_u),
    .out_ctl (rs_ctl),
    .root    (root)
  );

  assign push      = en && rs_ctl.valid;
  assign push_data = rs_ctl.bypass ? isf_pkg::ONE_Q30 : root;

  // output register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        map_factor <= skid_data;
        skid_data  <= push_data;
      end else begin
        map_factor <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/isf_checker.sv =====
// Port-level checks for the slant mapping factor block, bound to the top.
// Depends on isf_pkg and iono_slant_mapping_factor.
`default_nettype none

module isf_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [isf_pkg::ELEV_W-1:0]      elevation_deg,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [isf_pkg::FACTOR_W-1:0]    map_factor
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(elevation_deg))
    else $error("input changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(map_factor))
    else $error("result changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (map_factor >= 32'h4000_0000) && (map_factor < 32'hC000_0000))
    else $error("factor outside 1.0 to 3.0");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

endmodule

bind iono_slant_mapping_factor isf_checker u_isf_checker (.*);

`default_nettype wire
